@@ rtl/wsab_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsab_pkg
// Shared constants, types and arithmetic helpers of the sample
// accumulation buffer.
// ----------------------------------------------------------------------------
package wsab_pkg;

   localparam int MAX_WIDTH         = 512;
   localparam int MAX_HEIGHT        = 512;
   localparam int FRACTION_BITS     = 16;
   localparam int GAMMA_TABLE_BITS  = 12;

   localparam int COL_BITS   = $clog2(MAX_WIDTH);
   localparam int ROW_BITS   = $clog2(MAX_HEIGHT);
   localparam int ADDR_BITS  = COL_BITS + ROW_BITS;
   localparam int PIXELS     = MAX_WIDTH * MAX_HEIGHT;
   localparam int DIM_BITS   = 10;
   localparam int FLOAT_BITS = 32;
   localparam int SUM_BITS   = 48;
   localparam int AVG_BITS   = 32;
   localparam int AVG_FRAC   = 16;
   localparam int QUO_BITS   = SUM_BITS + AVG_FRAC;
   localparam int WORD_BITS  = 4 * SUM_BITS;
   localparam int GAMMA_SIZE = (1 << GAMMA_TABLE_BITS) + 1;
   localparam int GAMMA_SHIFT = AVG_FRAC - GAMMA_TABLE_BITS;
   localparam int GAMMA_HALF  = (GAMMA_SHIFT == 0) ? 0 : (1 << (GAMMA_SHIFT - 1));

   // operation codes
   localparam logic [1:0] OP_ADD   = 2'd0;
   localparam logic [1:0] OP_CLEAR = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   // status codes
   localparam logic [1:0] STATUS_DONE       = 2'd0;
   localparam logic [1:0] STATUS_NOT_FINITE = 2'd1;
   localparam logic [1:0] STATUS_OUTSIDE    = 2'd2;

   // register indexes
   localparam logic REG_FRAME_WIDTH  = 1'b0;
   localparam logic REG_FRAME_HEIGHT = 1'b1;

   localparam logic signed [SUM_BITS-1:0] POS_LIMIT = {1'b0, {(SUM_BITS-1){1'b1}}};
   localparam logic signed [SUM_BITS-1:0] NEG_LIMIT = {1'b1, {(SUM_BITS-1){1'b0}}};

   typedef enum logic [1:0] {
      JOB_REPORT,
      JOB_ADD,
      JOB_CLEAR,
      JOB_READ
   } job_kind_type;

   typedef struct packed {
      job_kind_type                 kind;
      logic [1:0]                   status;
      logic [ADDR_BITS-1:0]         addr;
      logic signed [SUM_BITS-1:0]   red;
      logic signed [SUM_BITS-1:0]   green;
      logic signed [SUM_BITS-1:0]   blue;
      logic signed [SUM_BITS-1:0]   weight;
   } job_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_ADD_FETCH,
      ST_READ_FETCH,
      ST_DIV_START,
      ST_DIVIDE,
      ST_GAMMA,
      ST_FINISH
   } back_state_type;

   // Value (-1)^neg * p * 2^s rounded half away from zero, saturated to 48 bits.
   function automatic logic signed [SUM_BITS-1:0] to_fixed(
      input logic                  neg,
      input logic [SUM_BITS-1:0]   p,
      input logic signed [9:0]     s
   );
      logic [SUM_BITS-1:0]   lim;
      logic [SUM_BITS-1:0]   mag;
      logic [2*SUM_BITS-1:0] wide;
      logic [SUM_BITS:0]     rnd;
      logic [9:0]            t;
      lim  = neg ? NEG_LIMIT : POS_LIMIT;
      wide = '0;
      rnd  = '0;
      t    = 10'(-s);
      if (p == '0) begin
         mag = '0;
      end else if (s >= 10'sd0) begin
         if (s >= 10'sd48) begin
            mag = lim;
         end else begin
            wide = {{SUM_BITS{1'b0}}, p} << s[5:0];
            mag  = (wide > {{SUM_BITS{1'b0}}, lim}) ? lim : wide[SUM_BITS-1:0];
         end
      end else if (t >= 10'd49) begin
         mag = '0;
      end else begin
         rnd = ({1'b0, p} + ((SUM_BITS+1)'(1) << (t[5:0] - 6'd1))) >> t[5:0];
         mag = (rnd > {1'b0, lim}) ? lim : rnd[SUM_BITS-1:0];
      end
      return $signed(neg ? (~mag + SUM_BITS'(1)) : mag);
   endfunction

   function automatic logic signed [SUM_BITS-1:0] sat_add(
      input logic signed [SUM_BITS-1:0] a,
      input logic signed [SUM_BITS-1:0] b
   );
      logic signed [SUM_BITS:0] r;
      r = {a[SUM_BITS-1], a} + {b[SUM_BITS-1], b};
      if (r[SUM_BITS] != r[SUM_BITS-1]) begin
         return r[SUM_BITS] ? NEG_LIMIT : POS_LIMIT;
      end
      return r[SUM_BITS-1:0];
   endfunction

   // Entry i is round(255 * (i/N)^(1/2.2)), found by exact integer compares:
   // byte >= k  <=>  510^11 * i^5 >= (2k-1)^11 * N^5, with N = 2^GAMMA_TABLE_BITS.
   function automatic logic [8*GAMMA_SIZE-1:0] build_gamma();
      logic [255:0]          thr [255];
      logic [255:0]          lhs;
      logic [255:0]          v;
      logic [8*GAMMA_SIZE-1:0] tab;
      int                    k;
      int                    i;
      int                    j;
      tab = '0;
      for (k = 1; k <= 255; k++) begin
         v = 256'd1;
         for (j = 0; j < 11; j++) v = v * 256'(2 * k - 1);
         for (j = 0; j < 5; j++) v = v * 256'(1 << GAMMA_TABLE_BITS);
         thr[k-1] = v;
      end
      k = 0;
      for (i = 0; i < GAMMA_SIZE; i++) begin
         lhs = 256'd1;
         for (j = 0; j < 5; j++) lhs = lhs * 256'(i);
         for (j = 0; j < 11; j++) lhs = lhs * 256'd510;
         while (k < 255 && lhs >= thr[k]) k++;
         tab[i*8 +: 8] = 8'(k);
      end
      return tab;
   endfunction

   localparam logic [8*GAMMA_SIZE-1:0] GAMMA_TABLE = build_gamma();

endpackage

@@ rtl/wsab_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsab_req_if / wsab_rsp_if
// Valid/ready channels for request items and response items.
// ----------------------------------------------------------------------------
interface wsab_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  operation;
   logic [8:0]  row;
   logic [8:0]  column;
   logic [31:0] red_bits;
   logic [31:0] green_bits;
   logic [31:0] blue_bits;
   logic [31:0] weight_bits;

   modport source (output valid, operation, row, column, red_bits, green_bits,
                   blue_bits, weight_bits, input ready);
   modport sink   (input valid, operation, row, column, red_bits, green_bits,
                   blue_bits, weight_bits, output ready);
endinterface

interface wsab_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         status;
   logic [7:0]         red_byte;
   logic [7:0]         green_byte;
   logic [7:0]         blue_byte;
   logic signed [31:0] average_red;
   logic signed [31:0] average_green;
   logic signed [31:0] average_blue;

   modport source (output valid, status, red_byte, green_byte, blue_byte,
                   average_red, average_green, average_blue, input ready);
   modport sink   (input valid, status, red_byte, green_byte, blue_byte,
                   average_red, average_green, average_blue, output ready);
endinterface

@@ rtl/wsab_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsab_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module wsab_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     write_enable,
   input  logic [$clog2(DEPTH)-1:0] write_address,
   input  logic [WIDTH-1:0]         write_data,
   input  logic [$clog2(DEPTH)-1:0] read_address,
   output logic [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] storage_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         storage_ff[write_address] <= write_data;
      end
      read_data_ff <= storage_ff[read_address];
   end

   assign read_data = read_data_ff;

endmodule

@@ rtl/wsab_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsab_front
// Accept request items, classify them, check the frame and turn the sample
// into fixed-point increments for the back end.
// ----------------------------------------------------------------------------
module wsab_front import wsab_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write_enable,
   input  logic                csr_index,
   input  logic [DIM_BITS-1:0] csr_write_data,
   input  logic                accept_enable,
   wsab_req_if.sink            req,
   output job_type             job,
   output logic                job_valid,
   input  logic                job_ready
);

   logic [DIM_BITS-1:0] frame_width_ff, frame_width_in;
   logic [DIM_BITS-1:0] frame_height_ff, frame_height_in;

   // first stage: raw item
   logic                  s1_valid_ff, s1_valid_in;
   logic [1:0]            s1_op_ff;
   logic [ROW_BITS-1:0]   s1_row_ff;
   logic [COL_BITS-1:0]   s1_col_ff;
   logic [FLOAT_BITS-1:0] s1_bits_ff [4];

   // second stage: classified item with mantissa products
   logic                       s2_valid_ff, s2_valid_in;
   job_kind_type               s2_kind_ff;
   logic [1:0]                 s2_status_ff;
   logic [ADDR_BITS-1:0]       s2_addr_ff;
   logic [SUM_BITS-1:0]        s2_prod_ff [4];
   logic signed [9:0]          s2_shift_ff [4];
   logic                       s2_neg_ff [4];

   logic                 s2_advance;
   logic                 s1_advance;
   logic                 accept;
   logic [DIM_BITS-1:0]  width_eff;
   logic [DIM_BITS-1:0]  height_eff;
   logic                 outside;
   logic                 not_finite;
   logic [DIM_BITS-1:0]  row_flip;
   job_kind_type         kind;
   logic [1:0]           status;
   logic [23:0]          mant [4];
   logic signed [9:0]    expo [4];

   // configuration registers
   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            REG_FRAME_WIDTH:  frame_width_in  = csr_write_data;
            REG_FRAME_HEIGHT: frame_height_in = csr_write_data;
            default:          frame_width_in  = frame_width_ff;
         endcase
      end
   end

   // handshake between stages
   assign s2_advance  = !s2_valid_ff || job_ready;
   assign s1_advance  = s1_valid_ff && s2_advance;
   assign req.ready   = accept_enable && (!s1_valid_ff || s2_advance);
   assign accept      = req.valid && req.ready;
   assign s1_valid_in = accept ? 1'b1 : (s1_advance ? 1'b0 : s1_valid_ff);
   assign s2_valid_in = s1_advance ? 1'b1 : (job_ready ? 1'b0 : s2_valid_ff);

   // effective frame size
   always_comb begin
      if (frame_width_ff == '0) width_eff = DIM_BITS'(1);
      else if (frame_width_ff > DIM_BITS'(MAX_WIDTH)) width_eff = DIM_BITS'(MAX_WIDTH);
      else width_eff = frame_width_ff;
      if (frame_height_ff == '0) height_eff = DIM_BITS'(1);
      else if (frame_height_ff > DIM_BITS'(MAX_HEIGHT)) height_eff = DIM_BITS'(MAX_HEIGHT);
      else height_eff = frame_height_ff;
   end

   // decode the four singles
   always_comb begin
      not_finite = 1'b0;
      for (int c = 0; c < 4; c++) begin
         if (s1_bits_ff[c][30:23] == 8'hFF) not_finite = 1'b1;
         if (s1_bits_ff[c][30:23] == 8'h00) begin
            mant[c] = {1'b0, s1_bits_ff[c][22:0]};
            expo[c] = -10'sd149;
         end else begin
            mant[c] = {1'b1, s1_bits_ff[c][22:0]};
            expo[c] = $signed({2'b00, s1_bits_ff[c][30:23]}) - 10'sd150;
         end
      end
   end

   // classify
   assign outside  = ({1'b0, s1_col_ff} >= width_eff) || ({1'b0, s1_row_ff} >= height_eff);
   assign row_flip = height_eff - DIM_BITS'(1) - {1'b0, s1_row_ff};

   always_comb begin
      kind   = JOB_REPORT;
      status = STATUS_DONE;
      priority case (s1_op_ff)
         OP_ADD: begin
            if (not_finite) status = STATUS_NOT_FINITE;
            else if (outside) status = STATUS_OUTSIDE;
            else kind = JOB_ADD;
         end
         OP_CLEAR: begin
            kind = JOB_CLEAR;
         end
         OP_READ: begin
            if (outside) status = STATUS_OUTSIDE;
            else kind = JOB_READ;
         end
         default: begin
            kind = JOB_REPORT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= DIM_BITS'(MAX_WIDTH);
         frame_height_ff <= DIM_BITS'(MAX_HEIGHT);
         s1_valid_ff     <= 1'b0;
         s2_valid_ff     <= 1'b0;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
         s1_valid_ff     <= s1_valid_in;
         s2_valid_ff     <= s2_valid_in;
      end
   end

   // capture the accepted item
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_op_ff      <= req.operation;
         s1_row_ff     <= req.row;
         s1_col_ff     <= req.column;
         s1_bits_ff[0] <= req.red_bits;
         s1_bits_ff[1] <= req.green_bits;
         s1_bits_ff[2] <= req.blue_bits;
         s1_bits_ff[3] <= req.weight_bits;
      end
   end

   // multiply each color mantissa by the weight mantissa
   always_ff @(posedge clock) begin
      if (s1_advance) begin
         s2_kind_ff   <= kind;
         s2_status_ff <= status;
         s2_addr_ff   <= (s1_op_ff == OP_ADD) ? {row_flip[ROW_BITS-1:0], s1_col_ff}
                                              : {s1_row_ff, s1_col_ff};
         for (int c = 0; c < 3; c++) begin
            s2_prod_ff[c]  <= mant[c] * mant[3];
            s2_shift_ff[c] <= expo[c] + expo[3] + 10'(FRACTION_BITS);
            s2_neg_ff[c]   <= s1_bits_ff[c][31] ^ s1_bits_ff[3][31];
         end
         s2_prod_ff[3]  <= {{(SUM_BITS-24){1'b0}}, mant[3]};
         s2_shift_ff[3] <= expo[3] + 10'(FRACTION_BITS);
         s2_neg_ff[3]   <= s1_bits_ff[3][31];
      end
   end

   // round and saturate into the queue entry
   always_comb begin
      job.kind   = s2_kind_ff;
      job.status = s2_status_ff;
      job.addr   = s2_addr_ff;
      job.red    = to_fixed(s2_neg_ff[0], s2_prod_ff[0], s2_shift_ff[0]);
      job.green  = to_fixed(s2_neg_ff[1], s2_prod_ff[1], s2_shift_ff[1]);
      job.blue   = to_fixed(s2_neg_ff[2], s2_prod_ff[2], s2_shift_ff[2]);
      job.weight = to_fixed(s2_neg_ff[3], s2_prod_ff[3], s2_shift_ff[3]);
   end

   assign job_valid = s2_valid_ff;

endmodule

@@ rtl/wsab_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsab_queue
// Two-entry queue of classified jobs between the front and back ends.
// ----------------------------------------------------------------------------
module wsab_queue import wsab_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  job_type push_job,
   input  logic    push_valid,
   output logic    push_ready,
   output job_type head_job,
   output logic    head_valid,
   input  logic    pop
);

   job_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;

   assign push_ready = (count_ff != 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_job   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;

   // advance pointers and occupancy
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   assert property (@(posedge clock) disable iff (reset) count_ff != 2'd3)
      else $error("queue occupancy beyond two entries");
   assert property (@(posedge clock) disable iff (reset) pop |-> head_valid)
      else $error("queue popped while empty");
   assert property (@(posedge clock) disable iff (reset)
                    (push && !pop) |=> (count_ff == $past(count_ff) + 2'd1))
      else $error("queue occupancy lost a push");

endmodule

@@ rtl/wsab_divider.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsab_divider
// Restoring divider, one quotient bit per cycle, with round-half-up result.
// ----------------------------------------------------------------------------
module wsab_divider import wsab_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [QUO_BITS-1:0] dividend,
   input  logic [SUM_BITS-1:0] divisor,
   output logic                done,
   output logic [QUO_BITS-1:0] quotient
);

   localparam int COUNT_BITS = $clog2(QUO_BITS + 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [SUM_BITS-1:0]   rem_ff;
   logic [SUM_BITS-1:0]   den_ff;
   logic [QUO_BITS-1:0]   num_ff;
   logic [QUO_BITS-1:0]   quo_ff;
   logic [SUM_BITS:0]     rem_shift;
   logic                  fits;
   logic                  round_up;

   // one trial subtraction
   assign rem_shift = {rem_ff, num_ff[QUO_BITS-1]};
   assign fits      = rem_shift >= {1'b0, den_ff};
   assign round_up  = {rem_ff, 1'b0} >= {1'b0, den_ff};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = COUNT_BITS'(QUO_BITS);
      end else if (busy_ff) begin
         count_in = count_ff - COUNT_BITS'(1);
         if (count_ff == COUNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= dividend;
         den_ff <= divisor;
         rem_ff <= '0;
         quo_ff <= '0;
      end else if (busy_ff) begin
         rem_ff <= fits ? SUM_BITS'(rem_shift - {1'b0, den_ff}) : rem_shift[SUM_BITS-1:0];
         quo_ff <= {quo_ff[QUO_BITS-2:0], fits};
         num_ff <= {num_ff[QUO_BITS-2:0], 1'b0};
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff + QUO_BITS'(round_up);

   assert property (@(posedge clock) disable iff (reset) done_ff |-> !busy_ff)
      else $error("divider reports done while still iterating");
   assert property (@(posedge clock) disable iff (reset)
                    (busy_ff && !start) |-> (count_ff != '0))
      else $error("divider iterating with an empty step count");
   assert property (@(posedge clock) disable iff (reset)
                    busy_ff |-> (rem_ff < den_ff))
      else $error("divider remainder not below divisor");

endmodule

@@ rtl/wsab_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsab_back
// Carry out queued jobs against the pixel memory: accumulate, clear and
// resolve reads through the shared divider and the gamma table.
// ----------------------------------------------------------------------------
module wsab_back import wsab_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  job_type head_job,
   input  logic    head_valid,
   output logic    pop,
   output logic    init_busy,
   wsab_rsp_if.source rsp
);

   back_state_type state_ff, state_in;
   logic                 init_ff, init_in;
   logic [ADDR_BITS-1:0] clear_pos_ff, clear_pos_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   job_type              job_ff;
   logic [1:0]           ch_ff;
   logic signed [SUM_BITS-1:0] sum_ff [3];
   logic [SUM_BITS-1:0]  den_ff;
   logic signed [AVG_BITS-1:0] avg_ff [3];
   logic [7:0]           byte_ff [3];

   logic [1:0]           rsp_status_ff;
   logic [7:0]           rsp_byte_ff [3];
   logic signed [AVG_BITS-1:0] rsp_avg_ff [3];

   logic                 ram_we;
   logic [ADDR_BITS-1:0] ram_waddr;
   logic [WORD_BITS-1:0] ram_wdata;
   logic [ADDR_BITS-1:0] ram_raddr;
   logic [WORD_BITS-1:0] ram_rdata;
   logic                 div_start;
   logic                 div_done;
   logic [QUO_BITS-1:0]  div_quotient;
   logic                 load_rsp;
   logic                 clear_last;
   logic signed [SUM_BITS-1:0] cur_sum;
   logic [SUM_BITS-1:0]  cur_abs;
   logic signed [AVG_BITS-1:0] avg_sat;
   logic signed [AVG_BITS-1:0] cur_avg;
   logic [AVG_FRAC:0]    gamma_clamp;
   logic [AVG_FRAC+1:0]  gamma_round;
   logic [GAMMA_TABLE_BITS:0] gamma_idx;
   logic [7:0]           gamma_byte;
   logic signed [SUM_BITS-1:0] mem_weight;

   wsab_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (PIXELS)
   ) u_ram (
      .clock         (clock),
      .write_enable  (ram_we),
      .write_address (ram_waddr),
      .write_data    (ram_wdata),
      .read_address  (ram_raddr),
      .read_data     (ram_rdata)
   );

   wsab_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({cur_abs, {AVG_FRAC{1'b0}}}),
      .divisor  (den_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign clear_last = (clear_pos_ff == {ADDR_BITS{1'b1}});
   assign mem_weight = ram_rdata[SUM_BITS-1:0];
   assign load_rsp   = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp.ready);
   assign init_busy  = init_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (head_valid) begin
               unique case (head_job.kind)
                  JOB_REPORT: state_in = ST_FINISH;
                  JOB_ADD:    state_in = ST_ADD_FETCH;
                  JOB_CLEAR:  state_in = ST_CLEAR;
                  JOB_READ:   state_in = ST_READ_FETCH;
                  default:    state_in = ST_FINISH;
               endcase
            end
         end
         ST_CLEAR: begin
            if (clear_last) state_in = init_ff ? ST_IDLE : ST_FINISH;
         end
         ST_ADD_FETCH: begin
            state_in = ST_FINISH;
         end
         ST_READ_FETCH: begin
            if (mem_weight[SUM_BITS-1] || mem_weight == '0) state_in = ST_FINISH;
            else state_in = ST_DIV_START;
         end
         ST_DIV_START: begin
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (div_done) state_in = ST_GAMMA;
         end
         ST_GAMMA: begin
            state_in = (ch_ff == 2'd2) ? ST_FINISH : ST_DIV_START;
         end
         ST_FINISH: begin
            if (load_rsp) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state outputs: memory, divider and queue control
   always_comb begin
      pop       = (state_ff == ST_IDLE) && head_valid;
      ram_raddr = (state_ff == ST_IDLE) ? head_job.addr : job_ff.addr;
      ram_we    = (state_ff == ST_CLEAR) || (state_ff == ST_ADD_FETCH);
      ram_waddr = (state_ff == ST_CLEAR) ? clear_pos_ff : job_ff.addr;
      div_start = (state_ff == ST_DIV_START);
      if (state_ff == ST_CLEAR) begin
         ram_wdata = '0;
      end else begin
         ram_wdata = {sat_add($signed(ram_rdata[4*SUM_BITS-1:3*SUM_BITS]), job_ff.red),
                      sat_add($signed(ram_rdata[3*SUM_BITS-1:2*SUM_BITS]), job_ff.green),
                      sat_add($signed(ram_rdata[2*SUM_BITS-1:SUM_BITS]), job_ff.blue),
                      sat_add(mem_weight, job_ff.weight)};
      end
   end

   // channel selection for the divider and saturation of its quotient
   always_comb begin
      cur_sum = sum_ff[ch_ff];
      cur_abs = cur_sum[SUM_BITS-1] ? SUM_BITS'(-cur_sum) : cur_sum;
      if (cur_sum[SUM_BITS-1]) begin
         avg_sat = (div_quotient > QUO_BITS'(33'h0_8000_0000))
                   ? $signed({1'b1, {(AVG_BITS-1){1'b0}}})
                   : $signed(AVG_BITS'(-div_quotient[AVG_BITS-1:0]));
      end else begin
         avg_sat = (div_quotient > QUO_BITS'(32'h7FFF_FFFF))
                   ? $signed({1'b0, {(AVG_BITS-1){1'b1}}})
                   : $signed(div_quotient[AVG_BITS-1:0]);
      end
   end

   // gamma lookup of the current channel's average
   always_comb begin
      cur_avg     = avg_ff[ch_ff];
      gamma_clamp = (cur_avg > $signed(AVG_BITS'(1 << AVG_FRAC)))
                    ? (AVG_FRAC+1)'(1 << AVG_FRAC) : cur_avg[AVG_FRAC:0];
      gamma_round = {1'b0, gamma_clamp} + (AVG_FRAC+2)'(GAMMA_HALF);
      gamma_idx   = (GAMMA_TABLE_BITS+1)'(gamma_round >> GAMMA_SHIFT);
      if (cur_avg <= $signed(AVG_BITS'(0))) gamma_byte = 8'd0;
      else gamma_byte = GAMMA_TABLE[{gamma_idx, 3'b000} +: 8];
   end

   // control registers
   always_comb begin
      init_in      = init_ff;
      clear_pos_in = clear_pos_ff;
      if (state_ff == ST_IDLE && head_valid && head_job.kind == JOB_CLEAR) begin
         clear_pos_in = '0;
      end else if (state_ff == ST_CLEAR) begin
         clear_pos_in = clear_pos_ff + ADDR_BITS'(1);
         if (clear_last) init_in = 1'b0;
      end
      rsp_valid_in = load_rsp ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         init_ff      <= 1'b1;
         clear_pos_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_ff      <= init_in;
         clear_pos_ff <= clear_pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working registers of the current job
   always_ff @(posedge clock) begin
      if (pop) begin
         job_ff <= head_job;
         for (int c = 0; c < 3; c++) begin
            avg_ff[c]  <= '0;
            byte_ff[c] <= '0;
         end
      end
      if (state_ff == ST_READ_FETCH) begin
         sum_ff[0] <= $signed(ram_rdata[4*SUM_BITS-1:3*SUM_BITS]);
         sum_ff[1] <= $signed(ram_rdata[3*SUM_BITS-1:2*SUM_BITS]);
         sum_ff[2] <= $signed(ram_rdata[2*SUM_BITS-1:SUM_BITS]);
         den_ff    <= mem_weight;
         ch_ff     <= 2'd0;
      end
      if (state_ff == ST_DIVIDE && div_done) begin
         avg_ff[ch_ff] <= avg_sat;
      end
      if (state_ff == ST_GAMMA) begin
         byte_ff[ch_ff] <= gamma_byte;
         ch_ff          <= ch_ff + 2'd1;
      end
   end

   // hold the finished result until it is taken
   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_status_ff <= job_ff.status;
         for (int c = 0; c < 3; c++) begin
            rsp_byte_ff[c] <= byte_ff[c];
            rsp_avg_ff[c]  <= avg_ff[c];
         end
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.status        = rsp_status_ff;
   assign rsp.red_byte      = rsp_byte_ff[0];
   assign rsp.green_byte    = rsp_byte_ff[1];
   assign rsp.blue_byte     = rsp_byte_ff[2];
   assign rsp.average_red   = rsp_avg_ff[0];
   assign rsp.average_green = rsp_avg_ff[1];
   assign rsp.average_blue  = rsp_avg_ff[2];

   assert property (@(posedge clock) disable iff (reset)
                    ram_we |-> (state_ff == ST_CLEAR || state_ff == ST_ADD_FETCH))
      else $error("pixel memory written outside accumulate or clear");
   assert property (@(posedge clock) disable iff (reset)
                    (state_ff == ST_ADD_FETCH) |-> ($past(state_ff) == ST_IDLE))
      else $error("accumulate used read data not fetched in the previous cycle");
   assert property (@(posedge clock) disable iff (reset)
                    init_ff |-> (state_ff == ST_CLEAR && !rsp_valid_ff))
      else $error("startup clearing pass interrupted");
   assert property (@(posedge clock) disable iff (reset)
                    (state_ff == ST_DIVIDE && div_done) |-> (ch_ff != 2'd3))
      else $error("divider result for a channel that does not exist");

endmodule

@@ rtl/weighted_sample_accumulation_buffer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weighted_sample_accumulation_buffer
// Per-pixel weighted radiance accumulator with linear and gamma read-out.
// ----------------------------------------------------------------------------
// Items are taken one at a time by the back end; a two-stage front end and a
// two-entry queue let a few requests be accepted ahead of it. An add sample
// passes through memory read, saturating update and write-back, and result
// load in the back end. A read runs the shared one-bit-per-cycle divider
// three times, one color after the other, unless the stored weight is not positive.
// A clear writes zero to all 262144 pixel locations, one per cycle, and
// reports when done. Rejected and out-of-frame items go straight to the
// result load, and a stalled response holds the back end in its result load.
// After reset the same clearing pass runs before the first request is
// accepted; register writes are taken during that time.
module weighted_sample_accumulation_buffer import wsab_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write_enable,
   input  logic                csr_index,
   input  logic [DIM_BITS-1:0] csr_write_data,
   wsab_req_if.sink            req_chan,
   wsab_rsp_if.source          rsp_chan
);

   job_type push_job;
   logic    push_valid;
   logic    push_ready;
   job_type head_job;
   logic    head_valid;
   logic    pop;
   logic    init_busy;

   wsab_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .accept_enable    (!init_busy),
      .req              (req_chan),
      .job              (push_job),
      .job_valid        (push_valid),
      .job_ready        (push_ready)
   );

   wsab_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_job   (push_job),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .head_job   (head_job),
      .head_valid (head_valid),
      .pop        (pop)
   );

   wsab_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_job   (head_job),
      .head_valid (head_valid),
      .pop        (pop),
      .init_busy  (init_busy),
      .rsp        (rsp_chan)
   );

endmodule

@@ bench/wsab_bench_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsab_bench_if
// Bench-side idle control shared by the request driver and response sink.
// ----------------------------------------------------------------------------
// Holds the switch that turns random idle bursts on or off for both sides
// of the accumulation buffer bench.
interface wsab_bench_if;
   logic idle_enable;

   modport source (output idle_enable);
   modport sink   (input idle_enable);
endinterface

@@ bench/weighted_sample_accumulation_buffer_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weighted_sample_accumulation_buffer_tb
// Self-checking bench for the weighted sample accumulation buffer.
// ----------------------------------------------------------------------------
// Drives add, clear and read transfers under several frame sizes. A bit-exact
// predictor of the pixel sums, the averages and the gamma bytes is kept in
// the bench. Every response transfer is checked against the oldest
// prediction. Both sides idle in random bursts, except in the final part.
module weighted_sample_accumulation_buffer_tb;
   import wsab_pkg::*;

   typedef struct {
      logic [1:0]         status;
      logic [7:0]         red_byte;
      logic [7:0]         green_byte;
      logic [7:0]         blue_byte;
      logic signed [31:0] average_red;
      logic signed [31:0] average_green;
      logic signed [31:0] average_blue;
   } pixel_result_type;

   localparam longint unsigned SUM_POS = 64'h0000_7FFF_FFFF_FFFF;
   localparam longint unsigned SUM_NEG = 64'h0000_8000_0000_0000;
   localparam int              CYCLE_LIMIT = 4_000_000;
   localparam int              DRAIN_CYCLES = 400;

   localparam logic [31:0] F_ZERO    = 32'h0000_0000;
   localparam logic [31:0] F_ONE     = 32'h3F80_0000;
   localparam logic [31:0] F_HALF    = 32'h3F00_0000;
   localparam logic [31:0] F_TWO     = 32'h4000_0000;
   localparam logic [31:0] F_NEG_ONE = 32'hBF80_0000;
   localparam logic [31:0] F_MAX     = 32'h7F7F_FFFF;
   localparam logic [31:0] F_DENORM  = 32'h0000_0001;
   localparam logic [31:0] F_HUGE    = 32'h7180_0000;
   localparam logic [31:0] F_INF     = 32'h7F80_0000;
   localparam logic [31:0] F_NAN     = 32'h7FC0_0000;

   logic clock;
   logic reset;
   logic                csr_write_enable;
   logic                csr_index;
   logic [DIM_BITS-1:0] csr_write_data;

   wsab_req_if   req_chan ();
   wsab_rsp_if   rsp_chan ();
   wsab_bench_if idle_ctl ();

   weighted_sample_accumulation_buffer dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan)
   );

   // predictor state
   longint        red_acc    [int];
   longint        green_acc  [int];
   longint        blue_acc   [int];
   longint        weight_acc [int];
   logic [7:0]    gamma_lut  [GAMMA_SIZE];
   int unsigned   width_reg;
   int unsigned   height_reg;
   pixel_result_type pending_results [$];
   int            error_count;
   int            cycle_count;
   int            ready_stall;

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   // ---------------------------------------------------------------- predictor
   function automatic void build_gamma_lut();
      logic [255:0] limit_k [255];
      logic [255:0] lhs;
      int           k;
      int           i;
      int           j;
      for (k = 1; k <= 255; k++) begin
         limit_k[k-1] = 256'd1;
         for (j = 0; j < 11; j++) limit_k[k-1] = limit_k[k-1] * 256'(2 * k - 1);
         for (j = 0; j < 5; j++) limit_k[k-1] = limit_k[k-1] * 256'(1 << GAMMA_TABLE_BITS);
      end
      k = 0;
      for (i = 0; i < GAMMA_SIZE; i++) begin
         lhs = 256'd1;
         for (j = 0; j < 5; j++) lhs = lhs * 256'(i);
         for (j = 0; j < 11; j++) lhs = lhs * 256'd510;
         while (k < 255 && lhs >= limit_k[k]) k++;
         gamma_lut[i] = 8'(k);
      end
   endfunction

   function automatic int unsigned clamp_dim(int unsigned v, int unsigned max_v);
      if (v == 0) return 1;
      return (v > max_v) ? max_v : v;
   endfunction

   function automatic bit is_special(logic [31:0] f);
      return f[30:23] == 8'hFF;
   endfunction

   // Split a single into integer mantissa and power of two.
   function automatic void unpack_single(logic [31:0] f, output longint unsigned mant,
                                         output int expo);
      if (f[30:23] == 8'h00) begin
         mant = {41'd0, f[22:0]};
         expo = -149;
      end else begin
         mant = {40'd0, 1'b1, f[22:0]};
         expo = int'(f[30:23]) - 150;
      end
   endfunction

   // Round p * 2^s half away from zero, saturate to the 48-bit sum range.
   function automatic longint scale_to_sum(bit neg, longint unsigned p, int s);
      longint unsigned lim;
      longint unsigned mag;
      lim = neg ? SUM_NEG : SUM_POS;
      if (p == 0) return 0;
      if (s >= 0) begin
         mag = (s >= 48 || p > (lim >> s)) ? lim : (p << s);
      end else if (-s >= 49) begin
         mag = 0;
      end else begin
         mag = (p + (64'd1 << (-s - 1))) >> (-s);
         if (mag > lim) mag = lim;
      end
      return neg ? -longint'(mag) : longint'(mag);
   endfunction

   function automatic longint clip_add(longint a, longint b);
      longint r;
      r = a + b;
      if (r > longint'(SUM_POS)) return longint'(SUM_POS);
      if (r < -longint'(SUM_NEG)) return -longint'(SUM_NEG);
      return r;
   endfunction

   function automatic longint weighted_color(logic [31:0] c, logic [31:0] w);
      longint unsigned mc;
      longint unsigned mw;
      int              ec;
      int              ew;
      unpack_single(c, mc, ec);
      unpack_single(w, mw, ew);
      return scale_to_sum(c[31] ^ w[31], mc * mw, ec + ew + FRACTION_BITS);
   endfunction

   function automatic logic signed [31:0] linear_average(longint sum, longint wsum);
      longint unsigned num;
      longint unsigned q;
      longint unsigned r;
      num = longint'(sum < 0 ? -sum : sum) << 16;
      q   = num / longint'(wsum);
      r   = num % longint'(wsum);
      if (r >= longint'(wsum) - r) q++;
      if (sum < 0) return (q > 64'h8000_0000) ? 32'sh8000_0000 : -32'(q);
      return (q > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : 32'(q);
   endfunction

   function automatic logic [7:0] gamma_byte_of(logic signed [31:0] avg);
      int unsigned c;
      if (avg <= 0) return 8'd0;
      c = (avg > 65536) ? 65536 : avg;
      return gamma_lut[(c + GAMMA_HALF) >> GAMMA_SHIFT];
   endfunction

   function automatic longint sum_at(ref longint store [int], input int addr);
      return store.exists(addr) ? store[addr] : 0;
   endfunction

   // Apply one accepted item to the model and return its response.
   function automatic pixel_result_type predict_pixel_result(logic [1:0] op, logic [8:0] row,
         logic [8:0] col, logic [31:0] rb, logic [31:0] gb, logic [31:0] bb, logic [31:0] wb);
      pixel_result_type res;
      int unsigned     w;
      int unsigned     h;
      int              addr;
      longint unsigned mw;
      int              ew;
      longint          ws;
      res = '{default: '0};
      w = clamp_dim(width_reg, MAX_WIDTH);
      h = clamp_dim(height_reg, MAX_HEIGHT);
      case (op)
         OP_ADD: begin
            if (is_special(rb) || is_special(gb) || is_special(bb) || is_special(wb)) begin
               res.status = STATUS_NOT_FINITE;
            end else if (col >= w || row >= h) begin
               res.status = STATUS_OUTSIDE;
            end else begin
               addr = (h - 1 - row) * MAX_WIDTH + col;
               red_acc[addr]   = clip_add(sum_at(red_acc, addr), weighted_color(rb, wb));
               green_acc[addr] = clip_add(sum_at(green_acc, addr), weighted_color(gb, wb));
               blue_acc[addr]  = clip_add(sum_at(blue_acc, addr), weighted_color(bb, wb));
               unpack_single(wb, mw, ew);
               weight_acc[addr] = clip_add(sum_at(weight_acc, addr),
                                           scale_to_sum(wb[31], mw, ew + FRACTION_BITS));
            end
         end
         OP_CLEAR: begin
            red_acc.delete();
            green_acc.delete();
            blue_acc.delete();
            weight_acc.delete();
         end
         OP_READ: begin
            if (col >= w || row >= h) begin
               res.status = STATUS_OUTSIDE;
            end else begin
               addr = row * MAX_WIDTH + col;
               ws = sum_at(weight_acc, addr);
               if (ws > 0) begin
                  res.average_red   = linear_average(sum_at(red_acc, addr), ws);
                  res.average_green = linear_average(sum_at(green_acc, addr), ws);
                  res.average_blue  = linear_average(sum_at(blue_acc, addr), ws);
                  res.red_byte   = gamma_byte_of(res.average_red);
                  res.green_byte = gamma_byte_of(res.average_green);
                  res.blue_byte  = gamma_byte_of(res.average_blue);
               end
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   // ---------------------------------------------------------------- checking
   task automatic report_mismatch(string what, longint got, longint want);
      error_count++;
      $display("[%0t] mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
   endtask

   // Drive ready with random stall bursts.
   always @(posedge clock) begin
      if (reset) begin
         ready_stall = 0;
         rsp_chan.ready <= 1'b1;
      end else if (ready_stall > 0) begin
         ready_stall--;
         rsp_chan.ready <= 1'b0;
      end else if (idle_ctl.idle_enable && $urandom_range(0, 7) == 0) begin
         ready_stall = $urandom_range(0, 15);
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   // Compare each response transfer with the oldest prediction.
   always @(posedge clock) begin
      pixel_result_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected response, status", rsp_chan.status, -1);
         end else begin
            want = pending_results.pop_front();
            if (rsp_chan.status !== want.status)
               report_mismatch("status", rsp_chan.status, want.status);
            if (rsp_chan.red_byte !== want.red_byte)
               report_mismatch("red_byte", rsp_chan.red_byte, want.red_byte);
            if (rsp_chan.green_byte !== want.green_byte)
               report_mismatch("green_byte", rsp_chan.green_byte, want.green_byte);
            if (rsp_chan.blue_byte !== want.blue_byte)
               report_mismatch("blue_byte", rsp_chan.blue_byte, want.blue_byte);
            if (rsp_chan.average_red !== want.average_red)
               report_mismatch("average_red", rsp_chan.average_red, want.average_red);
            if (rsp_chan.average_green !== want.average_green)
               report_mismatch("average_green", rsp_chan.average_green, want.average_green);
            if (rsp_chan.average_blue !== want.average_blue)
               report_mismatch("average_blue", rsp_chan.average_blue, want.average_blue);
         end
      end
   end

   // Stop a hung run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("weighted_sample_accumulation_buffer_tb: done, errors");
         $finish;
      end
   end

   // ---------------------------------------------------------------- stimulus
   task automatic send_item(logic [1:0] op, logic [8:0] row, logic [8:0] col,
         logic [31:0] rb, logic [31:0] gb, logic [31:0] bb, logic [31:0] wb);
      int gap;
      // sometimes insert an idle burst before the transfer
      if (idle_ctl.idle_enable && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 16);
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.operation   <= op;
      req_chan.row         <= row;
      req_chan.column      <= col;
      req_chan.red_bits    <= rb;
      req_chan.green_bits  <= gb;
      req_chan.blue_bits   <= bb;
      req_chan.weight_bits <= wb;
      do @(posedge clock); while (!req_chan.ready);
      pending_results.push_back(predict_pixel_result(op, row, col, rb, gb, bb, wb));
   endtask

   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_frame(logic [DIM_BITS-1:0] w, logic [DIM_BITS-1:0] h);
      csr_write_enable <= 1'b1;
      csr_index        <= REG_FRAME_WIDTH;
      csr_write_data   <= w;
      @(posedge clock);
      width_reg = w;
      csr_index        <= REG_FRAME_HEIGHT;
      csr_write_data   <= h;
      @(posedge clock);
      height_reg = h;
      csr_write_enable <= 1'b0;
   endtask

   function automatic logic [31:0] random_color();
      case ($urandom_range(0, 19))
         0:       return $urandom;
         1:       return {1'($urandom), 8'hFF, 23'($urandom)};
         2:       return {1'($urandom), 8'h00, 23'($urandom)};
         3:       return F_ZERO;
         default: return {($urandom_range(0, 9) == 0), 8'($urandom_range(112, 127)),
                          23'($urandom)};
      endcase
   endfunction

   function automatic logic [31:0] random_weight();
      case ($urandom_range(0, 19))
         0:       return $urandom;
         1:       return {1'($urandom), 8'hFF, 23'($urandom)};
         2:       return {1'b1, 8'($urandom_range(118, 128)), 23'($urandom)};
         default: return {1'b0, 8'($urandom_range(118, 129)), 23'($urandom)};
      endcase
   endfunction

   // Coordinate mostly inside a small corner, sometimes anywhere.
   function automatic logic [8:0] random_coord(int unsigned dim);
      int unsigned lim;
      lim = clamp_dim(dim, 512);
      if ($urandom_range(0, 9) == 0) return 9'($urandom);
      if ($urandom_range(0, 9) == 0) return 9'(lim);
      return 9'($urandom_range(0, (lim > 6 ? 6 : lim) - 1));
   endfunction

   task automatic send_random_item();
      int unsigned h;
      int          pick;
      logic [8:0]  row;
      h = clamp_dim(height_reg, MAX_HEIGHT);
      pick = $urandom_range(0, 99);
      row = random_coord(height_reg);
      if (pick < 60) begin
         send_item(OP_ADD, row, random_coord(width_reg), random_color(), random_color(),
                   random_color(), random_weight());
      end else if (pick < 97) begin
         // read back the stored row that a flipped add lands on
         if (row < h) row = 9'(h - 1 - row);
         send_item(OP_READ, row, random_coord(width_reg), $urandom, $urandom,
                   $urandom, $urandom);
      end else begin
         send_item(2'd3, 9'($urandom), 9'($urandom), $urandom, $urandom, $urandom, $urandom);
      end
   endtask

   // ---------------------------------------------------------------- tests
   task automatic test_field_extremes();
      send_item(OP_ADD, 9'd0, 9'd0, F_ONE, F_HALF, F_ZERO, F_TWO);
      send_item(OP_ADD, 9'd0, 9'd0, F_HALF, F_HALF, F_DENORM, F_ONE);
      send_item(OP_READ, 9'd511, 9'd0, F_ZERO, F_ZERO, F_ZERO, F_ZERO);
      send_item(OP_ADD, 9'd511, 9'd511, F_MAX, F_HUGE, 32'hFFFF_FFFF & ~F_INF | F_NEG_ONE,
                F_MAX);
      send_item(OP_ADD, 9'd511, 9'd511, F_NEG_ONE, F_DENORM, F_ONE, F_DENORM);
      send_item(OP_READ, 9'd0, 9'd511, F_ZERO, F_ZERO, F_ZERO, F_ZERO);
      send_item(OP_ADD, 9'd1, 9'd1, F_TWO, F_NEG_ONE, F_HALF, F_HALF);
      send_item(OP_READ, 9'd510, 9'd1, F_ZERO, F_ZERO, F_ZERO, F_ZERO);
      // non-finite channels and weight are rejected
      send_item(OP_ADD, 9'd2, 9'd2, F_INF, F_ONE, F_ONE, F_ONE);
      send_item(OP_ADD, 9'd2, 9'd2, F_ONE, F_NAN, F_ONE, F_ONE);
      send_item(OP_ADD, 9'd2, 9'd2, F_ONE, F_ONE, 32'hFF80_0000, F_ONE);
      send_item(OP_ADD, 9'd2, 9'd2, F_ONE, F_ONE, F_ONE, 32'hFFFF_FFFF);
      // negative weight sum reads as zero
      send_item(OP_ADD, 9'd3, 9'd3, F_ONE, F_ONE, F_ONE, F_NEG_ONE);
      send_item(OP_READ, 9'd508, 9'd3, F_ZERO, F_ZERO, F_ZERO, F_ZERO);
      send_item(OP_READ, 9'd100, 9'd100, F_ZERO, F_ZERO, F_ZERO, F_ZERO);
      send_item(2'd3, 9'd511, 9'd511, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                32'hFFFF_FFFF);
      // clear wipes the frame
      send_item(OP_CLEAR, 9'd0, 9'd0, F_ZERO, F_ZERO, F_ZERO, F_ZERO);
      send_item(OP_READ, 9'd511, 9'd0, F_ZERO, F_ZERO, F_ZERO, F_ZERO);
      wait_drained();
   endtask

   task automatic test_frame_limits();
      // zero acts as one
      write_frame(10'd0, 10'd0);
      send_item(OP_ADD, 9'd0, 9'd0, F_ONE, F_HALF, F_TWO, F_ONE);
      send_item(OP_ADD, 9'd0, 9'd1, F_ONE, F_ONE, F_ONE, F_ONE);
      send_item(OP_ADD, 9'd1, 9'd0, F_ONE, F_ONE, F_ONE, F_ONE);
      send_item(OP_READ, 9'd0, 9'd0, F_ZERO, F_ZERO, F_ZERO, F_ZERO);
      send_item(OP_READ, 9'd1, 9'd1, F_ZERO, F_ZERO, F_ZERO, F_ZERO);
      wait_drained();
      // above the maximum acts as the maximum
      write_frame(10'd1023, 10'd600);
      send_item(OP_ADD, 9'd0, 9'd511, F_HALF, F_HALF, F_HALF, F_ONE);
      send_item(OP_READ, 9'd511, 9'd511, F_ZERO, F_ZERO, F_ZERO, F_ZERO);
      wait_drained();
   endtask

   task automatic test_random_phases();
      int phase;
      int n;
      for (phase = 0; phase < 5; phase++) begin
         case (phase)
            0: write_frame(10'd8, 10'd8);
            1: write_frame(10'd3, 10'd17);
            2: write_frame(10'd1, 10'd1);
            3: write_frame(10'd512, 10'd512);
            default: write_frame(10'd6, 10'd5);
         endcase
         for (n = 0; n < 190; n++) send_random_item();
         if (phase == 2) send_item(OP_CLEAR, 9'($urandom), 9'($urandom), $urandom,
                                   $urandom, $urandom, $urandom);
         wait_drained();
      end
   endtask

   task automatic test_back_to_back();
      idle_ctl.idle_enable = 1'b0;
      write_frame(10'd7, 10'd4);
      repeat (150) send_random_item();
      wait_drained();
   endtask

   initial begin
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_index = REG_FRAME_WIDTH;
      csr_write_data = '0;
      req_chan.valid = 1'b0;
      req_chan.operation = OP_ADD;
      req_chan.row = '0;
      req_chan.column = '0;
      req_chan.red_bits = '0;
      req_chan.green_bits = '0;
      req_chan.blue_bits = '0;
      req_chan.weight_bits = '0;
      rsp_chan.ready = 1'b1;
      idle_ctl.idle_enable = 1'b1;
      error_count = 0;
      cycle_count = 0;
      width_reg = 512;
      height_reg = 512;
      build_gamma_lut();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_field_extremes();
      test_frame_limits();
      test_random_phases();
      test_back_to_back();

      if (error_count == 0) begin
         $display("weighted_sample_accumulation_buffer_tb: done, clean");
      end else begin
         $display("weighted_sample_accumulation_buffer_tb: done, errors");
      end
      $finish;
   end

endmodule
